// ----- src/particle_billboard_expander_assert.svh -----
// assertion macros for the billboard expander
`ifndef PARTICLE_BILLBOARD_EXPANDER_ASSERT_SVH
`define PARTICLE_BILLBOARD_EXPANDER_ASSERT_SVH

// implication checked on every clock edge outside reset
`define PBE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pbe check failed");

// next-cycle implication
`define PBE_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pbe check failed");

`endif

// ----- src/pbe_pkg.sv -----
package pbe_pkg;

  localparam int PosW   = 32;
  localparam int LifeW  = 17;
  localparam int OriW   = 16;
  localparam int AxisW  = 48;
  localparam int SizeW  = 16;
  localparam int ColW   = 32;
  localparam int CfgIdxW = 3;
  localparam int QueueDepthDef = 2;
  localparam logic [LifeW-1:0] LifeOne = 17'd65536;

  localparam logic [CfgIdxW-1:0] CfgRight      = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgUp         = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgSizeStart  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgSizeEnd    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgColorStart = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgColorEnd   = 3'd5;

  // one particle after the front end: centre, size-scaled push vectors, colour
  typedef struct packed {
    logic signed [PosW-1:0] pos_x;
    logic signed [PosW-1:0] pos_y;
    logic signed [PosW-1:0] pos_z;
    logic signed [PosW+8:0] p_x;
    logic signed [PosW+8:0] p_y;
    logic signed [PosW+8:0] p_z;
    logic signed [PosW+8:0] q_x;
    logic signed [PosW+8:0] q_y;
    logic signed [PosW+8:0] q_z;
    logic [ColW-1:0]        color;
  } quad_t;

  // lerp between value at life zero and value at life one, 16-bit fraction
  function automatic logic [15:0] lerp16(input logic [15:0] a0, input logic [15:0] a1,
                                         input logic [LifeW-1:0] l);
    logic [33:0] acc;
    acc = 34'(a0) * 34'(LifeOne - l) + 34'(a1) * 34'(l) + 34'd32768;
    return acc[31:16];
  endfunction

  function automatic logic signed [PosW-1:0] sat32(input logic signed [PosW+10:0] v);
    if (v > 43'sd2147483647) return 32'sh7fffffff;
    else if (v < -43'sd2147483648) return 32'sh80000000;
    else return v[PosW-1:0];
  endfunction

endpackage

// ----- src/pbe_front.sv -----
module pbe_front import pbe_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [PosW-1:0]  in_pos_x,
  input  logic signed [PosW-1:0]  in_pos_y,
  input  logic signed [PosW-1:0]  in_pos_z,
  input  logic [LifeW-1:0]        in_life_frac,
  input  logic signed [OriW-1:0]  in_orient_xx,
  input  logic signed [OriW-1:0]  in_orient_xy,
  input  logic signed [OriW-1:0]  in_orient_yx,
  input  logic signed [OriW-1:0]  in_orient_yy,
  input  logic [AxisW-1:0]        right_axis,
  input  logic [AxisW-1:0]        up_axis,
  input  logic [SizeW-1:0]        size_start,
  input  logic [SizeW-1:0]        size_end,
  input  logic [ColW-1:0]         color_start,
  input  logic [ColW-1:0]         color_end,
  output logic                    fr_valid,
  input  logic                    fr_stall,
  output quad_t                   fr_quad
);

  // stage 1: size/colour lerp; stage 2: axis*size; stage 3: weighted sums
  logic s1_v_r, s2_v_r, s3_v_r;
  logic s1_v_nxt, s2_v_nxt, s3_v_nxt;
  logic adv1, adv2, adv3;

  logic signed [PosW-1:0] s1_px_r, s1_py_r, s1_pz_r, s2_px_r, s2_py_r, s2_pz_r;
  logic signed [OriW-1:0] s1_o_r [4];
  logic signed [OriW-1:0] s2_o_r [4];
  logic [SizeW-1:0]       s1_size_r;
  logic [ColW-1:0]        s1_col_r, s2_col_r;
  logic signed [32:0]     s2_r_r [3];
  logic signed [32:0]     s2_u_r [3];
  quad_t                  s3_q_r;

  logic [LifeW-1:0] life;
  logic [ColW-1:0]  col;

  assign adv3 = !s3_v_r || !fr_stall;
  assign adv2 = !s2_v_r || adv3;
  assign adv1 = !s1_v_r || adv2;
  assign in_stall = !adv1;
  assign fr_valid = s3_v_r;
  assign fr_quad  = s3_q_r;

  always_comb begin
    life = (in_life_frac > LifeOne) ? LifeOne : in_life_frac;
    for (int c = 0; c < 4; c++) begin
      col[8*c +: 8] = 8'(lerp16({8'd0, color_end[8*c +: 8]},
                                {8'd0, color_start[8*c +: 8]}, life));
    end
    s1_v_nxt = adv1 ? in_valid : s1_v_r;
    s2_v_nxt = adv2 ? s1_v_r : s2_v_r;
    s3_v_nxt = adv3 ? s2_v_r : s3_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
      s3_v_r <= s3_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_px_r   <= in_pos_x;
      s1_py_r   <= in_pos_y;
      s1_pz_r   <= in_pos_z;
      s1_o_r[0] <= in_orient_xx;
      s1_o_r[1] <= in_orient_xy;
      s1_o_r[2] <= in_orient_yx;
      s1_o_r[3] <= in_orient_yy;
      s1_size_r <= lerp16(size_end, size_start, life);
      s1_col_r  <= col;
    end
    if (adv2) begin
      s2_px_r  <= s1_px_r;
      s2_py_r  <= s1_py_r;
      s2_pz_r  <= s1_pz_r;
      s2_o_r   <= s1_o_r;
      s2_col_r <= s1_col_r;
      for (int c = 0; c < 3; c++) begin
        s2_r_r[c] <= $signed(right_axis[16*c +: 16]) * $signed({1'b0, s1_size_r});
        s2_u_r[c] <= $signed(up_axis[16*c +: 16]) * $signed({1'b0, s1_size_r});
      end
    end
    if (adv3) begin
      s3_q_r.pos_x <= s2_px_r;
      s3_q_r.pos_y <= s2_py_r;
      s3_q_r.pos_z <= s2_pz_r;
      s3_q_r.color <= s2_col_r;
      s3_q_r.p_x <= 41'((50'(s2_r_r[0]) * 50'(s2_o_r[0]) + 50'(s2_u_r[0]) * 50'(s2_o_r[1])
                         + 50'sd524288) >>> 20);
      s3_q_r.p_y <= 41'((50'(s2_r_r[1]) * 50'(s2_o_r[0]) + 50'(s2_u_r[1]) * 50'(s2_o_r[1])
                         + 50'sd524288) >>> 20);
      s3_q_r.p_z <= 41'((50'(s2_r_r[2]) * 50'(s2_o_r[0]) + 50'(s2_u_r[2]) * 50'(s2_o_r[1])
                         + 50'sd524288) >>> 20);
      s3_q_r.q_x <= 41'((50'(s2_r_r[0]) * 50'(s2_o_r[2]) + 50'(s2_u_r[0]) * 50'(s2_o_r[3])
                         + 50'sd524288) >>> 20);
      s3_q_r.q_y <= 41'((50'(s2_r_r[1]) * 50'(s2_o_r[2]) + 50'(s2_u_r[1]) * 50'(s2_o_r[3])
                         + 50'sd524288) >>> 20);
      s3_q_r.q_z <= 41'((50'(s2_r_r[2]) * 50'(s2_o_r[2]) + 50'(s2_u_r[2]) * 50'(s2_o_r[3])
                         + 50'sd524288) >>> 20);
    end
  end

endmodule

// ----- src/pbe_queue.sv -----
module pbe_queue import pbe_pkg::*; #(
  parameter int Depth = QueueDepthDef
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr_valid,
  output logic  wr_stall,
  input  quad_t wr_data,
  output logic  rd_valid,
  input  logic  rd_take,
  output quad_t rd_data
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  quad_t           mem_r [Depth];
  logic [PtrW-1:0] wp_r, rp_r, wp_nxt, rp_nxt;
  logic [PtrW:0]   cnt_r, cnt_nxt;
  logic            push, pop;

  assign wr_stall = (cnt_r == (PtrW+1)'(Depth));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];
  assign push = wr_valid && !wr_stall;
  assign pop  = rd_valid && rd_take;

  always_comb begin
    wp_nxt = wp_r;
    rp_nxt = rp_r;
    if (push) wp_nxt = (wp_r == PtrW'(Depth-1)) ? '0 : wp_r + 1'b1;
    if (pop)  rp_nxt = (rp_r == PtrW'(Depth-1)) ? '0 : rp_r + 1'b1;
    cnt_nxt = cnt_r + (PtrW+1)'(push) - (PtrW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_data;
  end

endmodule

// ----- src/pbe_back.sv -----
module pbe_back import pbe_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  output logic                   q_take,
  input  quad_t                  q_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [PosW-1:0] out_vert_x,
  output logic signed [PosW-1:0] out_vert_y,
  output logic signed [PosW-1:0] out_vert_z,
  output logic                   out_tex_u,
  output logic                   out_tex_v,
  output logic [ColW-1:0]        out_vert_color,
  output logic                   out_last_corner
);

  // corner counter walks (-,-) (+,-) (+,+) (-,+); output register per corner
  logic [1:0] k_r, k_nxt;
  logic       v_r, v_nxt;
  logic       load, su, sv;
  logic signed [PosW+10:0] ex, ey, ez;

  assign load   = q_valid && (!v_r || !out_stall);
  assign q_take = load && (k_r == 2'd3);
  assign su = (k_r == 2'd1) || (k_r == 2'd2);
  assign sv = k_r[1];
  assign out_valid = v_r;

  always_comb begin
    ex = 43'(q_data.pos_x) + (su ? 43'(q_data.p_x) : -43'(q_data.p_x))
                           + (sv ? 43'(q_data.q_x) : -43'(q_data.q_x));
    ey = 43'(q_data.pos_y) + (su ? 43'(q_data.p_y) : -43'(q_data.p_y))
                           + (sv ? 43'(q_data.q_y) : -43'(q_data.q_y));
    ez = 43'(q_data.pos_z) + (su ? 43'(q_data.p_z) : -43'(q_data.p_z))
                           + (sv ? 43'(q_data.q_z) : -43'(q_data.q_z));
    k_nxt = load ? k_r + 2'd1 : k_r;
    v_nxt = load ? 1'b1 : (out_stall ? v_r : 1'b0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
      v_r <= 1'b0;
    end else begin
      k_r <= k_nxt;
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_vert_x      <= sat32(ex);
      out_vert_y      <= sat32(ey);
      out_vert_z      <= sat32(ez);
      out_tex_u       <= su;
      out_tex_v       <= sv;
      out_vert_color  <= q_data.color;
      out_last_corner <= (k_r == 2'd3);
    end
  end

endmodule

// ----- src/particle_billboard_expander.sv -----
// path: an item's first corner leaves through the 3 front stages, the queue and the corner
// register; the back end then emits the other three one per cycle while out_stall is low,
// and the front and queue take new items while earlier ones are still draining
// reset: synchronous active-low rst_n clears pipeline valids, queue pointers, the corner
// counter and loads the register defaults
module particle_billboard_expander import pbe_pkg::*; #(
  parameter int QueueDepth = QueueDepthDef
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic signed [PosW-1:0] in_pos_x,
  input  logic signed [PosW-1:0] in_pos_y,
  input  logic signed [PosW-1:0] in_pos_z,
  input  logic [LifeW-1:0]       in_life_frac,
  input  logic signed [OriW-1:0] in_orient_xx,
  input  logic signed [OriW-1:0] in_orient_xy,
  input  logic signed [OriW-1:0] in_orient_yx,
  input  logic signed [OriW-1:0] in_orient_yy,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [PosW-1:0] out_vert_x,
  output logic signed [PosW-1:0] out_vert_y,
  output logic signed [PosW-1:0] out_vert_z,
  output logic                   out_tex_u,
  output logic                   out_tex_v,
  output logic [ColW-1:0]        out_vert_color,
  output logic                   out_last_corner,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CfgIdxW-1:0]     cfg_index,
  input  logic [63:0]            cfg_data
);

  // camera and lerp registers
  logic [AxisW-1:0] right_r, up_r;
  logic [SizeW-1:0] size_start_r, size_end_r;
  logic [ColW-1:0]  color_start_r, color_end_r;

  // front to queue, queue to back
  logic  fr_valid, fr_stall, q_valid, q_take;
  quad_t fr_quad, q_data;

  assign cfg_ready = 1'b1;

  // out-of-range indexes fall through and are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      right_r       <= '0;
      up_r          <= '0;
      size_start_r  <= 16'd256;
      size_end_r    <= 16'd256;
      color_start_r <= 32'hffffffff;
      color_end_r   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CfgRight:      right_r       <= cfg_data[AxisW-1:0];
        CfgUp:         up_r          <= cfg_data[AxisW-1:0];
        CfgSizeStart:  size_start_r  <= cfg_data[SizeW-1:0];
        CfgSizeEnd:    size_end_r    <= cfg_data[SizeW-1:0];
        CfgColorStart: color_start_r <= cfg_data[ColW-1:0];
        CfgColorEnd:   color_end_r   <= cfg_data[ColW-1:0];
        default: ;
      endcase
    end
  end

  // front end: clamp life, lerp size/colour, build the push vectors
  pbe_front u_front (
    .clk, .rst_n, .in_valid, .in_stall,
    .in_pos_x, .in_pos_y, .in_pos_z, .in_life_frac,
    .in_orient_xx, .in_orient_xy, .in_orient_yx, .in_orient_yy,
    .right_axis(right_r), .up_axis(up_r),
    .size_start(size_start_r), .size_end(size_end_r),
    .color_start(color_start_r), .color_end(color_end_r),
    .fr_valid, .fr_stall, .fr_quad
  );

  // short queue so the front keeps working while corners drain
  pbe_queue #(.Depth(QueueDepth)) u_queue (
    .clk, .rst_n,
    .wr_valid(fr_valid), .wr_stall(fr_stall), .wr_data(fr_quad),
    .rd_valid(q_valid), .rd_take(q_take), .rd_data(q_data)
  );

  // back end: four saturated corners per particle
  pbe_back u_back (
    .clk, .rst_n, .q_valid, .q_take, .q_data,
    .out_valid, .out_stall, .out_vert_x, .out_vert_y, .out_vert_z,
    .out_tex_u, .out_tex_v, .out_vert_color, .out_last_corner
  );

endmodule

// ----- src/pbe_checker.sv -----
module pbe_checker import pbe_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_stall,
  input logic out_tex_u,
  input logic out_tex_v,
  input logic out_last_corner,
  input logic [ColW-1:0] out_vert_color
);
`include "particle_billboard_expander_assert.svh"

  // the last corner is the (-,+) one
  `PBE_ASSERT_IMP(a_last_tex, out_valid && out_last_corner, !out_tex_u && out_tex_v)
  // a (-,-) corner is never the last one
  `PBE_ASSERT_IMP(a_corner_order, out_valid && !out_tex_u && !out_tex_v, !out_last_corner)
  // a held result keeps its colour
  `PBE_ASSERT_NXT(a_hold, out_valid && out_stall, out_valid && $stable(out_vert_color))
  // corners of one particle after (+,+) come (-,+)
  `PBE_ASSERT_NXT(a_seq, out_valid && !out_stall && out_tex_u && out_tex_v,
                  !out_valid || out_last_corner)

endmodule

bind particle_billboard_expander pbe_checker u_pbe_checker (
  .clk, .rst_n, .out_valid, .out_stall,
  .out_tex_u, .out_tex_v, .out_last_corner, .out_vert_color
);
